[hdl/qph_pkg.sv]
package qph_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 31;
  localparam int SLOT_W      = 7;
  localparam int SIZE_W      = 8;
  localparam int BIT_W       = $clog2(KEY_W);
  localparam int S_DATA_W    = 40;
  localparam int M_DATA_W    = 40;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(127);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);

  // register index taken from paddr[2]
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_READ    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_READ,
    KIND_READ_OOR
  } kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_PROBE,
    B_RDATA,
    B_OUT
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] idx;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic              occupied;
    logic [KEY_W-1:0]  value;
  } result_t;

endpackage

[hdl/qph_ram.sv]
module qph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/qph_front.sv]
module qph_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  qph_pkg::op_e               in_op_i,
  input  logic [qph_pkg::KEY_W-1:0]  in_key_i,
  input  logic [qph_pkg::SLOT_W-1:0] in_idx_i,
  output logic                       q_valid_o,
  output qph_pkg::item_t             q_item_o,
  input  logic                       q_pop_i
);

  qph_pkg::item_t fifo_q [2];
  qph_pkg::item_t item;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  // classify: reads beyond the store are answered as empty
  always_comb begin
    item.key = in_key_i;
    item.idx = in_idx_i;
    if (in_op_i == qph_pkg::OP_INSERT) begin
      item.kind = qph_pkg::KIND_INSERT;
    end else if (int'(in_idx_i) < qph_pkg::TABLE_DEPTH) begin
      item.kind = qph_pkg::KIND_READ;
    end else begin
      item.kind = qph_pkg::KIND_READ_OOR;
    end
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

[hdl/qph_back.sv]
module qph_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [qph_pkg::SIZE_W-1:0] size_i,
  input  logic                       q_valid_i,
  input  qph_pkg::item_t             q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output qph_pkg::result_t           out_res_o
);

  localparam int AW = qph_pkg::ADDR_W;
  localparam int SW = qph_pkg::SIZE_W;
  localparam int KW = qph_pkg::KEY_W;

  qph_pkg::back_state_e state_q, state_d;

  logic [qph_pkg::TABLE_DEPTH-1:0] used_q, used_d;
  logic [KW-1:0]                   key_q, key_d;
  logic [KW-1:0]                   shift_q, shift_d;
  logic [qph_pkg::BIT_W-1:0]       bit_q, bit_d;
  logic [SW-1:0]                   pos_q, pos_d;
  logic [SW-1:0]                   inc_q, inc_d;
  logic [SW-1:0]                   cnt_q, cnt_d;
  logic                            rd_used_q, rd_used_d;
  qph_pkg::result_t                res_q, res_d;
  qph_pkg::result_t                out_q, out_d;
  logic                            out_vld_q, out_vld_d;

  logic [SW-1:0]   rem_shift, rem_next;
  logic [SW:0]     pos_sum, inc_sum;
  logic [SW-1:0]   pos_next, inc_next;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [KW-1:0]   ram_rdata;

  // one quotient bit per cycle; remainder stays below size so it fits SW bits
  assign rem_shift = {pos_q[SW-2:0], shift_q[KW-1]};
  assign rem_next  = (rem_shift >= size_i) ? rem_shift - size_i : rem_shift;

  // (key + (c+1)^2) = (key + c^2) + (2c+1), both kept reduced
  assign pos_sum  = {1'b0, pos_q} + {1'b0, inc_q};
  assign pos_next = (pos_sum >= {1'b0, size_i}) ? SW'(pos_sum - {1'b0, size_i})
                                                : SW'(pos_sum);
  assign inc_sum  = {1'b0, inc_q} + (SW+1)'(2);
  assign inc_next = (inc_sum >= {1'b0, size_i}) ? SW'(inc_sum - {1'b0, size_i})
                                                : SW'(inc_sum);

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    key_d     = key_q;
    shift_d   = shift_q;
    bit_d     = bit_q;
    pos_d     = pos_q;
    inc_d     = inc_q;
    cnt_d     = cnt_q;
    rd_used_d = rd_used_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = pos_q[AW-1:0];

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      qph_pkg::B_IDLE: begin
        ram_addr = q_item_i.idx[AW-1:0];
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.kind == qph_pkg::KIND_INSERT) begin
            key_d   = q_item_i.key;
            shift_d = q_item_i.key;
            bit_d   = qph_pkg::BIT_W'(KW - 1);
            pos_d   = '0;
            state_d = qph_pkg::B_DIV;
          end else begin
            rd_used_d = (q_item_i.kind == qph_pkg::KIND_READ) &&
                        used_q[q_item_i.idx[AW-1:0]];
            res_d.status = qph_pkg::ST_READ;
            res_d.slot   = q_item_i.idx;
            state_d      = qph_pkg::B_RDATA;
          end
        end
      end
      qph_pkg::B_DIV: begin
        pos_d   = rem_next;
        shift_d = {shift_q[KW-2:0], 1'b0};
        bit_d   = bit_q - qph_pkg::BIT_W'(1);
        if (bit_q == '0) begin
          inc_d   = SW'(1);
          cnt_d   = '0;
          state_d = qph_pkg::B_PROBE;
        end
      end
      qph_pkg::B_PROBE: begin
        res_d.occupied = 1'b0;
        res_d.value    = '0;
        if (!used_q[pos_q[AW-1:0]]) begin
          ram_we                 = 1'b1;
          used_d[pos_q[AW-1:0]]  = 1'b1;
          res_d.status           = qph_pkg::ST_PLACED;
          res_d.slot             = qph_pkg::SLOT_W'(pos_q);
          state_d                = qph_pkg::B_OUT;
        end else if (cnt_q == size_i - SW'(1)) begin
          res_d.status = qph_pkg::ST_DROPPED;
          res_d.slot   = '0;
          state_d      = qph_pkg::B_OUT;
        end else begin
          pos_d = pos_next;
          inc_d = inc_next;
          cnt_d = cnt_q + SW'(1);
        end
      end
      qph_pkg::B_RDATA: begin
        res_d.occupied = rd_used_q;
        res_d.value    = rd_used_q ? ram_rdata : '0;
        state_d        = qph_pkg::B_OUT;
      end
      qph_pkg::B_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = qph_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = qph_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= qph_pkg::B_IDLE;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    shift_q   <= shift_d;
    bit_q     <= bit_d;
    pos_q     <= pos_d;
    inc_q     <= inc_d;
    cnt_q     <= cnt_d;
    rd_used_q <= rd_used_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  qph_ram #(
    .WIDTH(KW),
    .DEPTH(qph_pkg::TABLE_DEPTH)
  ) u_keys (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(key_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

[hdl/quadratic_probe_hash_insert.sv]
// Read: states B_RDATA then B_OUT from input transfer to result; next item then follows.
// Insert: bit-serial key mod table_size (state B_DIV), then P probes (B_PROBE),
//   P = probes taken (1 .. table_size), one key-store probe per cycle.
// Two-entry queue lets up to two items be taken while one is worked on.
// Reset (rst_ni low, async): table empty, table_size = 127, no result pending.
module quadratic_probe_hash_insert (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [30:0] key, [37:31] slot_index, [39:38] zero
  input  logic [qph_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] op
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [6:0] slot, [7] slot_occupied, [38:8] slot_value, [39] zero
  output logic [qph_pkg::M_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]                   m_axis_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qph_pkg::APB_AW-1:0]   paddr,
  input  logic [qph_pkg::APB_DW-1:0]   pwdata,
  output logic [qph_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  logic [qph_pkg::SIZE_W-1:0] size_q, size_d;
  logic [qph_pkg::SIZE_W-1:0] size_eff;
  logic                       q_valid, q_pop;
  qph_pkg::item_t             q_item;
  qph_pkg::result_t           res;

  assign pready = 1'b1;

  always_comb begin
    size_d = size_q;
    if (psel && penable && pwrite && pready && paddr[2] == qph_pkg::REG_TABLE_SIZE) begin
      size_d = pwdata[qph_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= qph_pkg::SIZE_RESET;
    end else begin
      size_q <= size_d;
    end
  end

  assign prdata = (paddr[2] == qph_pkg::REG_TABLE_SIZE)
                ? qph_pkg::APB_DW'(size_q) : '0;

  always_comb begin
    if (size_q < qph_pkg::SIZE_MIN) begin
      size_eff = qph_pkg::SIZE_MIN;
    end else if (size_q > qph_pkg::SIZE_MAX) begin
      size_eff = qph_pkg::SIZE_MAX;
    end else begin
      size_eff = size_q;
    end
  end

  qph_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_op_i   (qph_pkg::op_e'(s_axis_tuser)),
    .in_key_i  (s_axis_tdata[qph_pkg::KEY_W-1:0]),
    .in_idx_i  (s_axis_tdata[qph_pkg::KEY_W +: qph_pkg::SLOT_W]),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  qph_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_eff),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {1'b0, res.value, res.occupied, res.slot};

endmodule

[hdl/qph_checker.sv]
module qph_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [qph_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == qph_pkg::ST_PLACED ||
                       m_axis_tuser == qph_pkg::ST_DROPPED ||
                       m_axis_tuser == qph_pkg::ST_READ))
    else $error("unknown status");

  a_insert_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != qph_pkg::ST_READ |-> m_axis_tdata[39:7] == '0)
    else $error("insert result carries slot data");

  a_empty_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == qph_pkg::ST_READ && !m_axis_tdata[7] |->
      m_axis_tdata[38:8] == '0)
    else $error("empty slot read returns a value");

  a_drop_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == qph_pkg::ST_DROPPED |-> m_axis_tdata[6:0] == '0)
    else $error("dropped key reports a slot");

endmodule

bind quadratic_probe_hash_insert qph_checker u_qph_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
